>>> sv/mcpf_pkg.sv
package mcpf_pkg;

    localparam int NumCells  = 19;
    localparam int NumData   = 18;
    localparam int CountW    = $clog2(NumCells + 1);
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;

    localparam logic [7:0]  AddrReset = 8'd128;
    localparam logic [31:0] PropReset = 32'd65000;
    localparam logic [31:0] IntReset  = 32'd32768;
    localparam logic [31:0] DerReset  = 32'd16384;
    localparam logic [31:0] MaxReset  = 32'd2300;

    localparam logic signed [31:0] DutyLimit = 32'sd1500;
    localparam logic [6:0]         SumMask   = 7'h7F;

    localparam logic [CfgIdxW-1:0] RegAddr = 3'd0;
    localparam logic [CfgIdxW-1:0] RegProp = 3'd1;
    localparam logic [CfgIdxW-1:0] RegInt  = 3'd2;
    localparam logic [CfgIdxW-1:0] RegDer  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMax  = 3'd4;

    localparam logic [3:0] CmdDrive1   = 4'd0;
    localparam logic [3:0] CmdDrive2   = 4'd1;
    localparam logic [3:0] CmdEnc1     = 4'd2;
    localparam logic [3:0] CmdEnc2     = 4'd3;
    localparam logic [3:0] CmdSpdRd1   = 4'd4;
    localparam logic [3:0] CmdSpdRd2   = 4'd5;
    localparam logic [3:0] CmdResetCnt = 4'd6;
    localparam logic [3:0] CmdPid1     = 4'd7;
    localparam logic [3:0] CmdPid2     = 4'd8;
    localparam logic [3:0] CmdDutyBoth = 4'd9;
    localparam logic [3:0] CmdSpeed1   = 4'd10;
    localparam logic [3:0] CmdSpeed2   = 4'd11;
    localparam logic [3:0] CmdSpeedMix = 4'd12;

    localparam logic [7:0] OpDrive1   = 8'd0;
    localparam logic [7:0] OpDrive2   = 8'd4;
    localparam logic [7:0] OpEnc1     = 8'd16;
    localparam logic [7:0] OpEnc2     = 8'd17;
    localparam logic [7:0] OpSpdRd1   = 8'd18;
    localparam logic [7:0] OpSpdRd2   = 8'd19;
    localparam logic [7:0] OpResetCnt = 8'd20;
    localparam logic [7:0] OpPid1     = 8'd28;
    localparam logic [7:0] OpPid2     = 8'd29;
    localparam logic [7:0] OpDutyBoth = 8'd34;
    localparam logic [7:0] OpSpeed1   = 8'd35;
    localparam logic [7:0] OpSpeed2   = 8'd36;
    localparam logic [7:0] OpSpeedMix = 8'd37;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic       occ;
        logic       last;
        logic       csum;
        logic [7:0] data;
    } t_cell;

    typedef struct packed {
        logic [7:0]  addr;
        logic [31:0] prop;
        logic [31:0] integ;
        logic [31:0] deriv;
        logic [31:0] max_tps;
    } t_regs;

    localparam t_cell EmptyCell = '{occ: 1'b0, last: 1'b0, csum: 1'b0, data: 8'd0};

endpackage

>>> sv/mcpf_cell.sv
module mcpf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_shift,
    input  mcpf_pkg::t_cell i_load_cell,
    input  mcpf_pkg::t_cell i_next_cell,
    output mcpf_pkg::t_cell o_cell
);

    mcpf_pkg::t_cell r_cell;
    mcpf_pkg::t_cell n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_load) begin
            n_cell = i_load_cell;
        end else if (i_shift) begin
            n_cell = i_next_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= mcpf_pkg::EmptyCell;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> sv/mcpf_frame.sv
module mcpf_frame (
    input  mcpf_pkg::t_in_item i_item,
    input  mcpf_pkg::t_regs    i_regs,
    output mcpf_pkg::t_cell    o_cells [mcpf_pkg::NumCells]
);

    logic [7:0]                  buf_b [mcpf_pkg::NumData];
    logic [mcpf_pkg::CountW-1:0] n_data;
    logic [mcpf_pkg::CountW-1:0] n_total;
    logic                        checked;
    logic                        known;
    logic [15:0]                 duty1;
    logic [15:0]                 duty2;
    logic [31:0]                 a_w;
    logic [31:0]                 b_w;

    function automatic logic [15:0] clamp_duty(input logic signed [31:0] v);
        logic [15:0] r;
        if (v > mcpf_pkg::DutyLimit) begin
            r = mcpf_pkg::DutyLimit[15:0];
        end else if (v < -mcpf_pkg::DutyLimit) begin
            r = 16'(-mcpf_pkg::DutyLimit);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign duty1 = clamp_duty(i_item.first_value);
    assign duty2 = clamp_duty(i_item.second_value);
    assign a_w   = i_item.first_value;
    assign b_w   = i_item.second_value;

    always_comb begin
        for (int i = 0; i < mcpf_pkg::NumData; i++) begin
            buf_b[i] = 8'd0;
        end
        buf_b[0] = i_regs.addr;
        n_data   = mcpf_pkg::CountW'(2);
        checked  = 1'b1;
        known    = 1'b1;
        case (i_item.cmd)
            mcpf_pkg::CmdDrive1, mcpf_pkg::CmdDrive2: begin
                buf_b[1] = (i_item.cmd == mcpf_pkg::CmdDrive1) ? mcpf_pkg::OpDrive1
                                                               : mcpf_pkg::OpDrive2;
                buf_b[2] = a_w[7:0];
                n_data   = mcpf_pkg::CountW'(3);
            end
            mcpf_pkg::CmdEnc1, mcpf_pkg::CmdEnc2: begin
                buf_b[1] = (i_item.cmd == mcpf_pkg::CmdEnc1) ? mcpf_pkg::OpEnc1
                                                             : mcpf_pkg::OpEnc2;
                checked  = 1'b0;
            end
            mcpf_pkg::CmdSpdRd1, mcpf_pkg::CmdSpdRd2: begin
                buf_b[1] = (i_item.cmd == mcpf_pkg::CmdSpdRd1) ? mcpf_pkg::OpSpdRd1
                                                               : mcpf_pkg::OpSpdRd2;
                n_data   = mcpf_pkg::CountW'(3);
            end
            mcpf_pkg::CmdResetCnt: begin
                buf_b[1] = mcpf_pkg::OpResetCnt;
            end
            mcpf_pkg::CmdPid1, mcpf_pkg::CmdPid2: begin
                buf_b[1] = (i_item.cmd == mcpf_pkg::CmdPid1) ? mcpf_pkg::OpPid1
                                                             : mcpf_pkg::OpPid2;
                for (int k = 0; k < 4; k++) begin
                    buf_b[2 + k]  = i_regs.deriv[31 - 8*k -: 8];
                    buf_b[6 + k]  = i_regs.prop[31 - 8*k -: 8];
                    buf_b[10 + k] = i_regs.integ[31 - 8*k -: 8];
                    buf_b[14 + k] = i_regs.max_tps[31 - 8*k -: 8];
                end
                n_data = mcpf_pkg::CountW'(18);
            end
            mcpf_pkg::CmdDutyBoth: begin
                buf_b[1] = mcpf_pkg::OpDutyBoth;
                buf_b[2] = duty1[15:8];
                buf_b[3] = duty1[7:0];
                buf_b[4] = duty2[15:8];
                buf_b[5] = duty2[7:0];
                n_data   = mcpf_pkg::CountW'(6);
            end
            mcpf_pkg::CmdSpeed1, mcpf_pkg::CmdSpeed2: begin
                buf_b[1] = (i_item.cmd == mcpf_pkg::CmdSpeed1) ? mcpf_pkg::OpSpeed1
                                                               : mcpf_pkg::OpSpeed2;
                for (int k = 0; k < 4; k++) begin
                    buf_b[2 + k] = a_w[31 - 8*k -: 8];
                end
                n_data = mcpf_pkg::CountW'(6);
            end
            mcpf_pkg::CmdSpeedMix: begin
                buf_b[1] = mcpf_pkg::OpSpeedMix;
                for (int k = 0; k < 4; k++) begin
                    buf_b[2 + k] = a_w[31 - 8*k -: 8];
                    buf_b[6 + k] = b_w[31 - 8*k -: 8];
                end
                n_data = mcpf_pkg::CountW'(10);
            end
            default: begin
                known = 1'b0;
            end
        endcase
        n_total = known ? (n_data + mcpf_pkg::CountW'(checked)) : '0;
    end

    always_comb begin
        for (int i = 0; i < mcpf_pkg::NumCells; i++) begin
            o_cells[i].occ  = mcpf_pkg::CountW'(i) < n_total;
            o_cells[i].last = mcpf_pkg::CountW'(i + 1) == n_total;
            o_cells[i].csum = checked && (mcpf_pkg::CountW'(i) == n_data);
            o_cells[i].data = (i < mcpf_pkg::NumData) ? buf_b[i % mcpf_pkg::NumData] : 8'd0;
        end
    end

endmodule

>>> sv/motor_command_packet_framer_unit.sv
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_stall  | i_item  (cmd, first_value, second_value)
// output   | out       | o_valid / i_stall  | o_item  (tx_byte, last_byte)
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A request of n packet bytes (2 to 19) passes through the 19-cell byte chain,
// one byte leaving the head cell each cycle while i_stall does not hold it; codes 13 to 15 emit nothing.
// The next request is taken in the cycle the previous packet's last byte leaves the chain.
// Output is registered; i_stall holds the chain and the output register.
// Synchronous active-low reset empties the chain and loads register defaults.
module motor_command_packet_framer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mcpf_pkg::t_in_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mcpf_pkg::t_out_item                 o_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcpf_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [mcpf_pkg::CfgDataW-1:0]       i_cfg_data
);

    mcpf_pkg::t_regs     r_regs;
    mcpf_pkg::t_cell     load_cells [mcpf_pkg::NumCells];
    mcpf_pkg::t_cell     cells      [mcpf_pkg::NumCells];
    logic [6:0]          r_sum;
    logic                r_out_valid;
    mcpf_pkg::t_out_item r_out_item;
    logic                out_adv;
    logic                shift;
    logic                load;
    logic [7:0]          head_byte;
    logic [mcpf_pkg::NumCells-1:0] occ_vec;
    logic [mcpf_pkg::NumCells-1:0] last_vec;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.addr    <= mcpf_pkg::AddrReset;
            r_regs.prop    <= mcpf_pkg::PropReset;
            r_regs.integ   <= mcpf_pkg::IntReset;
            r_regs.deriv   <= mcpf_pkg::DerReset;
            r_regs.max_tps <= mcpf_pkg::MaxReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcpf_pkg::RegAddr: r_regs.addr    <= i_cfg_data[7:0];
                mcpf_pkg::RegProp: r_regs.prop    <= i_cfg_data;
                mcpf_pkg::RegInt:  r_regs.integ   <= i_cfg_data;
                mcpf_pkg::RegDer:  r_regs.deriv   <= i_cfg_data;
                mcpf_pkg::RegMax:  r_regs.max_tps <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mcpf_frame u_frame (
        .i_item  (i_item),
        .i_regs  (r_regs),
        .o_cells (load_cells)
    );

    assign out_adv = !r_out_valid || !i_stall;
    assign shift   = out_adv && cells[0].occ;
    assign o_stall = cells[0].occ && !(cells[0].last && out_adv);
    assign load    = i_valid && !o_stall;

    for (genvar g = 0; g < mcpf_pkg::NumCells; g++) begin : g_chain
        mcpf_pkg::t_cell next_cell;
        if (g == mcpf_pkg::NumCells - 1) begin : g_tail
            assign next_cell = mcpf_pkg::EmptyCell;
        end else begin : g_mid
            assign next_cell = cells[g + 1];
        end
        mcpf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (load),
            .i_shift     (shift),
            .i_load_cell (load_cells[g]),
            .i_next_cell (next_cell),
            .o_cell      (cells[g])
        );
        assign occ_vec[g]  = cells[g].occ;
        assign last_vec[g] = cells[g].last && cells[g].occ;
    end

    assign head_byte = cells[0].csum ? {1'b0, r_sum & mcpf_pkg::SumMask} : cells[0].data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (shift) begin
                r_sum <= cells[0].last ? 7'd0 : (r_sum + head_byte[6:0]);
            end
            if (out_adv) begin
                r_out_valid <= cells[0].occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_item.tx_byte   <= head_byte;
            r_out_item.last_byte <= cells[0].last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("chain holds a gap");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occ_vec != '0 |-> $onehot(last_vec))
        else $error("chain holds no single last byte");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cells[0].occ |-> r_sum == 7'd0)
        else $error("checksum not cleared between packets");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled output item changed");

endmodule

>>> tb/motor_command_packet_framer_unit_tb.sv
module motor_command_packet_framer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpf_pkg::*;

    localparam int DrainCycles = 30;
    localparam int HoldCycles  = 400;
    localparam int PhaseItems  = 57;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                i_stall     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    t_in_item            i_item      = '0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data  = '0;
    logic                o_stall;
    logic                o_valid;
    logic                o_cfg_ready;
    t_out_item           o_item;

    logic [7:0]  dev_addr;
    logic [31:0] gain_p;
    logic [31:0] gain_i;
    logic [31:0] gain_d;
    logic [31:0] full_speed;

    t_in_item   requests_to_send[$];
    t_out_item  framed_bytes[$];
    logic [7:0] packet[$];
    int         byte_errors = 0;

    motor_command_packet_framer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] clamp_duty(input logic signed [31:0] duty);
        logic signed [31:0] held;
        held = duty;
        if (duty > DutyLimit) begin
            held = DutyLimit;
        end else if (duty < -DutyLimit) begin
            held = -DutyLimit;
        end
        return held[15:0];
    endfunction

    function automatic void push_be(input logic [31:0] word, input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--) begin
            packet.push_back(word[8*k +: 8]);
        end
    endfunction

    function automatic void frame_request(input t_in_item req);
        logic [31:0] total;
        logic        with_sum;
        packet = {};
        with_sum = 1'b1;
        packet.push_back(dev_addr);
        case (req.cmd)
            CmdDrive1, CmdDrive2: begin
                packet.push_back((req.cmd == CmdDrive1) ? OpDrive1 : OpDrive2);
                packet.push_back(req.first_value[7:0]);
            end
            CmdEnc1, CmdEnc2: begin
                packet.push_back((req.cmd == CmdEnc1) ? OpEnc1 : OpEnc2);
                with_sum = 1'b0;
            end
            CmdSpdRd1, CmdSpdRd2: begin
                packet.push_back((req.cmd == CmdSpdRd1) ? OpSpdRd1 : OpSpdRd2);
                packet.push_back(8'd0);
            end
            CmdResetCnt: begin
                packet.push_back(OpResetCnt);
            end
            CmdPid1, CmdPid2: begin
                packet.push_back((req.cmd == CmdPid1) ? OpPid1 : OpPid2);
                push_be(gain_d, 4);
                push_be(gain_p, 4);
                push_be(gain_i, 4);
                push_be(full_speed, 4);
            end
            CmdDutyBoth: begin
                packet.push_back(OpDutyBoth);
                push_be({16'd0, clamp_duty(req.first_value)}, 2);
                push_be({16'd0, clamp_duty(req.second_value)}, 2);
            end
            CmdSpeed1, CmdSpeed2: begin
                packet.push_back((req.cmd == CmdSpeed1) ? OpSpeed1 : OpSpeed2);
                push_be(req.first_value, 4);
            end
            CmdSpeedMix: begin
                packet.push_back(OpSpeedMix);
                push_be(req.first_value, 4);
                push_be(req.second_value, 4);
            end
            default: begin
                return;
            end
        endcase
        if (with_sum) begin
            total = '0;
            foreach (packet[k]) total += packet[k];
            packet.push_back({1'b0, total[6:0] & SumMask});
        end
        foreach (packet[k]) begin
            framed_bytes.push_back('{tx_byte: packet[k], last_byte: (k == packet.size() - 1)});
        end
    endfunction

    function automatic t_in_item make_request(input logic [3:0] cmd, input logic [31:0] first,
                                              input logic [31:0] second);
        t_in_item req;
        req.cmd = cmd;
        req.first_value = first;
        req.second_value = second;
        return req;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(4000)) - 32'd2000;
            2: begin
                case ($urandom_range(7))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'($signed(DutyLimit));
                    3: return 32'(-DutyLimit);
                    4: return 32'($signed(DutyLimit) + 1);
                    5: return 32'(-DutyLimit - 1);
                    6: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            3: return 32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_request();
        logic [3:0] cmd;
        if ($urandom_range(19) == 0) begin
            cmd = 4'($urandom_range(int'(CmdSpeedMix) + 1, 15));
        end else begin
            cmd = 4'($urandom_range(int'(CmdSpeedMix)));
        end
        return make_request(cmd, random_value(), random_value());
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            RegAddr: dev_addr   = value[7:0];
            RegProp: gain_p     = value;
            RegInt:  gain_i     = value;
            RegDer:  gain_d     = value;
            RegMax:  full_speed = value;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] addr, input logic [31:0] prop,
                                 input logic [31:0] integ, input logic [31:0] deriv,
                                 input logic [31:0] speed);
        write_reg(RegAddr, addr);
        write_reg(RegProp, prop);
        write_reg(RegInt, integ);
        write_reg(RegDer, deriv);
        write_reg(RegMax, speed);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (requests_to_send.size() != 0 || i_valid || framed_bytes.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) begin
            requests_to_send.push_back(random_request());
        end
    endtask

    // sender: bursts of items separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                frame_request(i_item);
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (requests_to_send.size() != 0) begin
                    i_valid <= 1'b1;
                    i_item  <= requests_to_send.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: shifting stall pattern plus one long hold-off
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   hold_left  = 0;
    int   bytes_seen = 0;
    logic held_once  = 1'b0;
    logic [2:0] tick = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            tick <= tick + 1'b1;
            if (o_valid && !i_stall) begin
                bytes_seen++;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(3);
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held_once && bytes_seen >= 600) begin
                held_once = 1'b1;
                hold_left = HoldCycles;
                i_stall   <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(3) == 0);
                    2: i_stall <= ($urandom_range(9) < 6);
                    default: i_stall <= tick[2];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_bytes
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (framed_bytes.size() == 0) begin
                if (byte_errors < 10) begin
                    $display("unexpected byte: tx_byte %h last_byte %b",
                             o_item.tx_byte, o_item.last_byte);
                end
                byte_errors++;
            end else begin
                want = framed_bytes.pop_front();
                if (o_item.tx_byte !== want.tx_byte || o_item.last_byte !== want.last_byte) begin
                    if (byte_errors < 10) begin
                        $display("byte mismatch: tx_byte exp %h got %h, last_byte exp %b got %b",
                                 want.tx_byte, o_item.tx_byte, want.last_byte,
                                 o_item.last_byte);
                    end
                    byte_errors++;
                end
            end
        end
    end

    initial begin
        #(12 * 400_000);
        $display("motor_command_packet_framer_unit_tb NOT OK");
        $finish;
    end

    initial begin
        dev_addr   = AddrReset;
        gain_p     = PropReset;
        gain_i     = IntReset;
        gain_d     = DerReset;
        full_speed = MaxReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        requests_to_send.push_back(make_request(CmdDrive1, 32'h0, 32'h0));
        requests_to_send.push_back(make_request(CmdDrive2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        requests_to_send.push_back(make_request(CmdDrive1, 32'h0000_0080, 32'h0));
        requests_to_send.push_back(make_request(CmdEnc1, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdEnc2, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdSpdRd1, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdSpdRd2, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdResetCnt, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdPid1, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdPid2, $urandom, $urandom));
        requests_to_send.push_back(make_request(CmdDutyBoth, 32'h0, 32'h0));
        requests_to_send.push_back(make_request(CmdDutyBoth, 32'($signed(DutyLimit)),
                                                32'(-DutyLimit)));
        requests_to_send.push_back(make_request(CmdDutyBoth, 32'($signed(DutyLimit) + 1),
                                                32'(-DutyLimit - 1)));
        requests_to_send.push_back(make_request(CmdDutyBoth, 32'h7FFF_FFFF, 32'h8000_0000));
        requests_to_send.push_back(make_request(CmdDutyBoth, 32'h8000_0000, 32'h7FFF_FFFF));
        requests_to_send.push_back(make_request(CmdSpeed1, 32'h8000_0000, 32'h0));
        requests_to_send.push_back(make_request(CmdSpeed2, 32'h7FFF_FFFF, 32'h0));
        requests_to_send.push_back(make_request(CmdSpeedMix, 32'hFFFF_FFFF, 32'h0));
        requests_to_send.push_back(make_request(CmdSpeedMix, 32'h0, 32'hFFFF_FFFF));
        for (int c = int'(CmdSpeedMix) + 1; c < 16; c++) begin
            requests_to_send.push_back(make_request(4'(c), $urandom, $urandom));
        end
        requests_to_send.push_back(make_request(CmdSpeedMix, 32'h8000_0000, 32'h7FFF_FFFF));
        wait_drained();

        load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_random(PhaseItems);
        wait_drained();

        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        queue_random(PhaseItems);
        wait_drained();

        load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
        write_reg(CfgIdxW'(int'(RegMax) + 1 + $urandom_range(2)), $urandom);
        queue_random(PhaseItems);
        wait_drained();

        load_settings($urandom_range(255), $urandom, $urandom, $urandom, $urandom);
        queue_random(PhaseItems);
        wait_drained();

        if (byte_errors == 0 && framed_bytes.size() == 0) begin
            $display("motor_command_packet_framer_unit_tb OK");
        end else begin
            $display("motor_command_packet_framer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
